// ===== rtl/keyvalue_text_lexer_macros.svh =====
// Assertion macros for the key/value text lexer.
// Included by the RTL files that carry assertions; expects clk_i and rst_ni in scope.
`ifndef KEYVALUE_TEXT_LEXER_MACROS_SVH
`define KEYVALUE_TEXT_LEXER_MACROS_SVH

`ifndef ASSERT_OFF
`define KVL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kvl assertion failed");
`define KVL_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("kvl assertion failed");
`else
`define KVL_ASSERT(lbl, prop)
`define KVL_NEVER(lbl, prop)
`endif

`endif

// ===== rtl/kvl_pkg.sv =====
// Types, constants and lexing functions of the key/value text lexer.
// No dependencies; used by every module of the block.
package kvl_pkg;

  typedef enum logic [2:0] {
    ModeBetween  = 3'd0,
    ModeComment  = 3'd1,
    ModeQuoted   = 3'd2,
    ModeEscape   = 3'd3,
    ModeUnquoted = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    EvByte   = 3'd0,
    EvStrEnd = 3'd1,
    EvLbrace = 3'd2,
    EvRbrace = 3'd3,
    EvEnd    = 3'd4,
    EvUnterm = 3'd5
  } ev_kind_e;

  typedef enum logic [1:0] {
    BomFirst = 2'd0,
    BomEf    = 2'd1,
    BomEfBb  = 2'd2,
    BomDone  = 2'd3
  } bom_e;

  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] Bom0     = 8'hEF;
  localparam logic [7:0] Bom1     = 8'hBB;
  localparam logic [7:0] Bom2     = 8'hBF;

  // events per lexing phase, phases per word (EF replay, BB replay, byte, end)
  localparam int PhaseSlots = 3;
  localparam int NumPhases  = 4;
  localparam int NumSlots   = PhaseSlots * NumPhases;
  localparam int SlotW      = $clog2(NumSlots);
  localparam int QDepth     = 2;
  localparam int QPtrW      = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW      = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] text_byte;
    logic       was_quoted;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] text;
    logic       quoted;
  } ev_t;

  typedef struct packed {
    mode_e mode;
    logic  slash;
  } lex_st_t;

  typedef struct packed {
    lex_st_t                   st;
    ev_t   [PhaseSlots-1:0]    ev;
    logic  [PhaseSlots-1:0]    vld;
    logic  [1:0]               cnt;
  } lex_res_t;

  typedef struct packed {
    ev_t  [NumSlots-1:0] ev;
    logic [NumSlots-1:0] vld;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);
  endfunction

  function automatic lex_res_t lex_init(lex_st_t s);
    lex_res_t r;
    r     = '0;
    r.st  = s;
    return r;
  endfunction

  function automatic lex_res_t push_ev(lex_res_t r, ev_kind_e k, logic [7:0] b, logic q);
    lex_res_t o;
    o                = r;
    o.ev[o.cnt].kind   = k;
    o.ev[o.cnt].text   = (k == EvByte) ? b : 8'd0;
    o.ev[o.cnt].quoted = q;
    o.vld[o.cnt]       = 1'b1;
    o.cnt              = o.cnt + 2'd1;
    return o;
  endfunction

  function automatic lex_res_t between_f(lex_res_t r, logic [7:0] b);
    lex_res_t o;
    o = r;
    if (is_ws(b)) begin
      o = r;
    end else if (b == ChLbrace) begin
      o = push_ev(o, EvLbrace, 8'd0, 1'b0);
    end else if (b == ChRbrace) begin
      o = push_ev(o, EvRbrace, 8'd0, 1'b0);
    end else if (b == ChQuote) begin
      o.st.mode = ModeQuoted;
    end else if (b == ChSlash) begin
      o.st.slash = 1'b1;
    end else begin
      o = push_ev(o, EvByte, b, 1'b0);
      o.st.mode = ModeUnquoted;
    end
    return o;
  endfunction

  function automatic lex_res_t unquoted_f(lex_res_t r, logic [7:0] b);
    lex_res_t o;
    o = r;
    if (is_ws(b)) begin
      o = push_ev(o, EvStrEnd, 8'd0, 1'b0);
      o.st.mode = ModeBetween;
    end else if ((b == ChLbrace) || (b == ChRbrace) || (b == ChQuote)) begin
      o = push_ev(o, EvStrEnd, 8'd0, 1'b0);
      o.st.mode = ModeBetween;
      o = between_f(o, b);
    end else if (b == ChSlash) begin
      o.st.slash = 1'b1;
    end else begin
      o = push_ev(o, EvByte, b, 1'b0);
    end
    return o;
  endfunction

  function automatic lex_res_t lex_byte_f(lex_st_t s, logic [7:0] b);
    lex_res_t o;
    o = lex_init(s);
    unique case (s.mode)
      ModeComment: begin
        if (b == ChLf) o.st.mode = ModeBetween;
      end
      ModeQuoted: begin
        if (b == ChBslash) begin
          o.st.mode = ModeEscape;
        end else if (b == ChQuote) begin
          o = push_ev(o, EvStrEnd, 8'd0, 1'b1);
          o.st.mode = ModeBetween;
        end else begin
          o = push_ev(o, EvByte, b, 1'b1);
        end
      end
      ModeEscape: begin
        if (b == ChLowN)      o = push_ev(o, EvByte, ChLf, 1'b1);
        else if (b == ChLowT) o = push_ev(o, EvByte, ChTab, 1'b1);
        else if (b == ChLowR) o = push_ev(o, EvByte, ChCr, 1'b1);
        else                  o = push_ev(o, EvByte, b, 1'b1);
        o.st.mode = ModeQuoted;
      end
      ModeUnquoted: begin
        if (s.slash) begin
          o.st.slash = 1'b0;
          if (b == ChSlash) begin
            o = push_ev(o, EvStrEnd, 8'd0, 1'b0);
            o.st.mode = ModeComment;
          end else begin
            o = push_ev(o, EvByte, ChSlash, 1'b0);
            o = unquoted_f(o, b);
          end
        end else begin
          o = unquoted_f(o, b);
        end
      end
      default: begin
        o.st.mode = ModeBetween;
        if (s.slash) begin
          o.st.slash = 1'b0;
          if (b == ChSlash) begin
            o.st.mode = ModeComment;
          end else begin
            o = push_ev(o, EvByte, ChSlash, 1'b0);
            o.st.mode = ModeUnquoted;
            o = unquoted_f(o, b);
          end
        end else begin
          o = between_f(o, b);
        end
      end
    endcase
    return o;
  endfunction

  function automatic lex_res_t lex_end_f(lex_st_t s);
    lex_res_t o;
    o = lex_init(s);
    unique case (s.mode)
      ModeQuoted: begin
        o = push_ev(o, EvUnterm, 8'd0, 1'b1);
      end
      ModeEscape: begin
        o = push_ev(o, EvByte, ChBslash, 1'b1);
        o = push_ev(o, EvUnterm, 8'd0, 1'b1);
      end
      ModeUnquoted: begin
        if (s.slash) o = push_ev(o, EvByte, ChSlash, 1'b0);
        o = push_ev(o, EvStrEnd, 8'd0, 1'b0);
      end
      ModeComment: begin
        o = lex_init(s);
      end
      default: begin
        if (s.slash) begin
          o = push_ev(o, EvByte, ChSlash, 1'b0);
          o = push_ev(o, EvStrEnd, 8'd0, 1'b0);
        end
      end
    endcase
    o = push_ev(o, EvEnd, 8'd0, 1'b0);
    o.st.mode  = ModeBetween;
    o.st.slash = 1'b0;
    return o;
  endfunction

endpackage

// ===== rtl/kvl_front.sv =====
// Front end: accepts input words, tracks the byte order mark and lexer state,
// and forms one bundle of events per word. Depends on kvl_pkg.
module kvl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kvl_pkg::in_word_t  in_word_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kvl_pkg::q_stat_t   q_stat_i,
  output logic               push_o,
  output kvl_pkg::bundle_t   bundle_o
);
  import kvl_pkg::*;

  mode_e    mode_q;
  logic     slash_q;
  bom_e     bom_q, bom_d;
  logic     fin_q;
  logic     accept;
  logic     replay_ef, replay_bb, lex_cur;
  lex_st_t  st0;
  lex_res_t r_ef, r_bb, r_cur, r_end;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // mark prefix handling; held bytes are relexed ahead of the current byte
  always_comb begin
    replay_ef = 1'b0;
    replay_bb = 1'b0;
    lex_cur   = 1'b0;
    bom_d     = bom_q;
    if (in_word_i.has_byte) begin
      unique case (bom_q)
        BomFirst: begin
          if (in_word_i.data_byte == Bom0) begin
            bom_d = BomEf;
          end else begin
            bom_d   = BomDone;
            lex_cur = 1'b1;
          end
        end
        BomEf: begin
          if (in_word_i.data_byte == Bom1) begin
            bom_d = BomEfBb;
          end else begin
            replay_ef = 1'b1;
            bom_d     = BomDone;
            lex_cur   = 1'b1;
          end
        end
        BomEfBb: begin
          if (in_word_i.data_byte == Bom2) begin
            bom_d = BomDone;
          end else begin
            replay_ef = 1'b1;
            replay_bb = 1'b1;
            bom_d     = BomDone;
            lex_cur   = 1'b1;
          end
        end
        default: lex_cur = 1'b1;
      endcase
    end
    if (in_word_i.end_of_input) begin
      if ((bom_d == BomEf) || (bom_d == BomEfBb)) begin
        replay_ef = 1'b1;
        replay_bb = (bom_d == BomEfBb);
      end
      bom_d = BomDone;
    end
  end

  always_comb begin
    st0.mode  = mode_q;
    st0.slash = slash_q;
    r_ef  = replay_ef ? lex_byte_f(st0, Bom0) : lex_init(st0);
    r_bb  = replay_bb ? lex_byte_f(r_ef.st, Bom1) : lex_init(r_ef.st);
    r_cur = lex_cur ? lex_byte_f(r_bb.st, in_word_i.data_byte) : lex_init(r_bb.st);
    r_end = in_word_i.end_of_input ? lex_end_f(r_cur.st) : lex_init(r_cur.st);
  end

  always_comb begin
    bundle_o.ev[PhaseSlots-1:0]                = r_ef.ev;
    bundle_o.vld[PhaseSlots-1:0]               = r_ef.vld;
    bundle_o.ev[2*PhaseSlots-1:PhaseSlots]     = r_bb.ev;
    bundle_o.vld[2*PhaseSlots-1:PhaseSlots]    = r_bb.vld;
    bundle_o.ev[3*PhaseSlots-1:2*PhaseSlots]   = r_cur.ev;
    bundle_o.vld[3*PhaseSlots-1:2*PhaseSlots]  = r_cur.vld;
    bundle_o.ev[4*PhaseSlots-1:3*PhaseSlots]   = r_end.ev;
    bundle_o.vld[4*PhaseSlots-1:3*PhaseSlots]  = r_end.vld;
  end

  assign push_o = accept && !fin_q && (|bundle_o.vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeBetween;
      slash_q <= 1'b0;
      bom_q   <= BomFirst;
      fin_q   <= 1'b0;
    end else if (accept && !fin_q) begin
      mode_q  <= r_end.st.mode;
      slash_q <= r_end.st.slash;
      bom_q   <= bom_d;
      fin_q   <= in_word_i.end_of_input;
    end
  end

endmodule

// ===== rtl/kvl_queue.sv =====
// Short bundle queue between the front end and the event emitter.
// Depends on kvl_pkg.
`include "keyvalue_text_lexer_macros.svh"

module kvl_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kvl_pkg::bundle_t  push_data_i,
  input  logic              pop_i,
  output kvl_pkg::bundle_t  head_o,
  output kvl_pkg::q_stat_t  stat_o
);
  import kvl_pkg::*;

  bundle_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;

  function automatic logic [QPtrW-1:0] ptr_inc(logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  `KVL_NEVER(a_q_overflow, push_i && stat_o.full && !pop_i)
  `KVL_NEVER(a_q_underflow, pop_i && stat_o.empty)
  `KVL_ASSERT(a_q_push_fill, (push_i && !pop_i) |=> !stat_o.empty)

endmodule

// ===== rtl/kvl_emit.sv =====
// Back end: walks the head bundle into the output register, one event per cycle unless stalled.
// Depends on kvl_pkg.
`include "keyvalue_text_lexer_macros.svh"

module kvl_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kvl_pkg::bundle_t   head_i,
  input  kvl_pkg::q_stat_t   q_stat_i,
  output logic               pop_o,
  output kvl_pkg::out_word_t out_word_o,
  output logic               out_valid_o,
  input  logic               out_stall_i
);
  import kvl_pkg::*;

  logic [NumSlots-1:0] done_q, done_d, rem;
  logic [SlotW-1:0]    sel;
  logic                last, load;
  logic                out_valid_q;
  out_word_t           out_q;

  always_comb begin
    rem = head_i.vld & ~done_q;
    sel = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (rem[i]) sel = SlotW'(i);
    end
    last   = ((rem & ~(NumSlots'(1) << sel)) == '0);
    load   = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
    pop_o  = load && last;
    done_d = done_q;
    if (load) done_d = last ? '0 : (done_q | (NumSlots'(1) << sel));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else begin
      done_q <= done_d;
      if (!out_valid_q || !out_stall_i) out_valid_q <= !q_stat_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.event_kind  <= head_i.ev[sel].kind;
      out_q.text_byte   <= head_i.ev[sel].text;
      out_q.was_quoted  <= head_i.ev[sel].quoted;
      out_q.last_of_run <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `KVL_ASSERT(a_pop_marks_last, pop_o |=> out_q.last_of_run)
  `KVL_NEVER(a_head_not_drained, !q_stat_i.empty && (rem == '0))
  `KVL_NEVER(a_text_only_bytes, out_valid_q && (out_q.event_kind != EvByte) && (out_q.text_byte != 8'd0))

endmodule

// ===== rtl/keyvalue_text_lexer.sv =====
// Streaming lexer for brace-structured key/value text: one input word per cycle,
// lexer events out one per cycle. Top level; depends on kvl_pkg and its submodules.
//
// Each input word (byte and/or end flag) is lexed by the front end in the cycle it is
// accepted; its events (zero to five) are queued as one bundle in a two-entry queue,
// and the emitter sends them one per cycle while the output is not stalled, through a
// registered output, marking the last event of each word. Input is accepted every cycle
// the queue has room; words that give no events are not queued. The first event of a word
// passes through the queue and then the output register. Words after the end event are
// accepted and dropped until reset.
module keyvalue_text_lexer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kvl_pkg::in_word_t  in_word_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output kvl_pkg::out_word_t out_word_o,
  output logic               out_valid_o,
  input  logic               out_stall_i
);
  import kvl_pkg::*;

  q_stat_t q_stat;
  bundle_t push_data, head;
  logic    push, pop;

  kvl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .bundle_o   (push_data)
  );

  kvl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  kvl_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_word_o  (out_word_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
